// File: hdl/blfx_pkg.sv
package blfx_pkg;

  localparam int DEPTH  = 64;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = 6;
  localparam int LVL_W  = 6;
  localparam int WIDE_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_POP  = 3'd1;
  localparam logic [2:0] OP_DROP = 3'd2;
  localparam logic [2:0] OP_TAKE = 3'd3;
  localparam logic [2:0] OP_SKIP = 3'd4;

  typedef enum logic [2:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_DROP,
    CMD_TAKE,
    CMD_SKIP,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmdq_wr_t;

  typedef struct packed {
    logic empty;
    logic full;
  } cmdq_stat_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] i);
    return (i == PTR_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // Bytes held between head (slot before oldest) and tail (newest).
  function automatic logic [PTR_W-1:0] fill(input logic [PTR_W-1:0] t,
                                            input logic [PTR_W-1:0] h);
    logic [PTR_W:0] s;
    s = {1'b0, t} + (PTR_W + 1)'(DEPTH) - {1'b0, h};
    if (t >= h) s = {1'b0, t} - {1'b0, h};
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [LVL_W-1:0] lvl6(input logic [PTR_W-1:0] x);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(x);
    return w[LVL_W-1:0];
  endfunction

endpackage

// File: hdl/byte_fifo_line_extractor.sv
// Circular byte FIFO with line extraction, DEPTH slots, DEPTH-1 bytes held.
// Command channel: drive opcode, data_byte and count with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
// busy rises only when the two-entry command queue is full.
// Result channel: each result appears for exactly one cycle with strobe high
// on out_byte, has_byte, status, last and level; last marks the final result
// of a command. The receiver cannot stall, so results are never held back.
// With the back end idle, a single-result command is first written into the
// command queue and then answered through the registered strobe of the back
// end; the first byte of a pop run also passes the registered memory read.
// Push, drop and bad opcodes finish in S_IDLE; pop and take line output read
// each byte (S_POP_RD, registered memory read) and then emit it (S_POP_OUT);
// take line scans via S_SCAN_RD, S_SCAN_CHK and skip blank lines via
// S_SKIP_RD, S_SKIP_CHK per byte, as the storage has a single read port.
// Reset (rst, synchronous) empties the FIFO and the command queue; storage
// contents are not cleared and unwritten slots never reach the outputs.
module byte_fifo_line_extractor import blfx_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       opcode,
  input  logic [7:0]       data_byte,
  input  logic [CNT_W-1:0] count,
  output logic             strobe,
  output logic [7:0]       out_byte,
  output logic             has_byte,
  output logic             status,
  output logic             last,
  output logic [LVL_W-1:0] level
);

  cmdq_wr_t   q_wr;
  cmdq_stat_t q_stat;
  cmd_t       q_cmd;
  logic       q_pop;

  // Front: decode the opcode and hand the command to the queue.
  blfx_front u_front (
    .start     (start),
    .opcode    (opcode),
    .data_byte (data_byte),
    .count     (count),
    .q_full    (q_stat.full),
    .busy      (busy),
    .q_wr      (q_wr)
  );

  // Queue: decouple command intake from execution.
  blfx_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .pop    (q_pop),
    .rd_cmd (q_cmd),
    .stat   (q_stat)
  );

  // Back: execute commands against the byte storage and emit results.
  blfx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (~q_stat.empty),
    .cmd      (q_cmd),
    .q_pop    (q_pop),
    .strobe   (strobe),
    .out_byte (out_byte),
    .has_byte (has_byte),
    .status   (status),
    .last     (last),
    .level    (level)
  );

  // An accepted transaction is queued on the next cycle.
  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !q_stat.empty)
    else $error("accepted command missing from queue");

  // A byte result never reports failure.
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && has_byte |-> !status)
    else $error("byte result with failure status");

  // A result without a byte always closes its command.
  a_nobyte_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !has_byte |-> last)
    else $error("byte-less result not marked last");

  // Inside a run, strobe drops between bytes before the next byte follows.
  a_run_cadence: assert property (@(posedge clk) disable iff (rst)
    strobe && has_byte && !last |=> !strobe ##1 (strobe && has_byte))
    else $error("byte run broken");

endmodule

// File: hdl/blfx_front.sv
module blfx_front import blfx_pkg::*; (
  input  logic             start,
  input  logic [2:0]       opcode,
  input  logic [7:0]       data_byte,
  input  logic [CNT_W-1:0] count,
  input  logic             q_full,
  output logic             busy,
  output cmdq_wr_t         q_wr
);

  cmd_kind_t kind;

  always_comb begin
    unique case (opcode)
      OP_PUSH: kind = CMD_PUSH;
      OP_POP:  kind = CMD_POP;
      OP_DROP: kind = CMD_DROP;
      OP_TAKE: kind = CMD_TAKE;
      OP_SKIP: kind = CMD_SKIP;
      default: kind = CMD_BAD;
    endcase
  end

  assign busy          = q_full;
  assign q_wr.push     = start & ~q_full;
  assign q_wr.cmd.kind = kind;
  assign q_wr.cmd.data = data_byte;
  assign q_wr.cmd.count = count;

endmodule

// File: hdl/blfx_cmd_queue.sv
module blfx_cmd_queue import blfx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmdq_wr_t   wr,
  input  logic       pop,
  output cmd_t       rd_cmd,
  output cmdq_stat_t stat
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   used;
  logic              do_push;
  logic              do_pop;

  function automatic logic [QPTR_W-1:0] q_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.empty = (used == '0);
  assign stat.full  = (used == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign do_push    = wr.push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign rd_cmd     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) wr_ptr <= q_inc(wr_ptr);
      if (do_pop) rd_ptr <= q_inc(rd_ptr);
      if (do_push && !do_pop) begin
        used <= used + 1'b1;
      end else if (do_pop && !do_push) begin
        used <= used - 1'b1;
      end
    end
  end

endmodule

// File: hdl/blfx_back.sv
module blfx_back import blfx_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  cmd_t             cmd,
  output logic             q_pop,
  output logic             strobe,
  output logic [7:0]       out_byte,
  output logic             has_byte,
  output logic             status,
  output logic             last,
  output logic [LVL_W-1:0] level
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_POP_OUT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SKIP_RD,
    S_SKIP_CHK
  } state_t;

  state_t           state;
  logic [7:0]       storage [DEPTH];
  logic [7:0]       rd_data;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] scan_addr;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] lim;

  logic [PTR_W-1:0]  head_inc;
  logic [PTR_W-1:0]  tail_inc;
  logic [PTR_W-1:0]  lvl;
  logic [PTR_W-1:0]  lvl_adv;
  logic [PTR_W-1:0]  lvl_push;
  logic              full;
  logic              too_few;
  logic [WIDE_W-1:0] drop_sum;
  logic [PTR_W-1:0]  drop_head;
  logic [CNT_W-1:0]  take_lim;
  logic [WIDE_W-1:0] lvl_wide;
  logic              wr_en;
  logic              is_eol;

  assign head_inc = ptr_inc(head);
  assign tail_inc = ptr_inc(tail);
  assign lvl      = fill(tail, head);
  assign lvl_adv  = fill(tail, head_inc);
  assign lvl_push = fill(tail_inc, head);
  assign full     = (tail_inc == head);
  assign lvl_wide = WIDE_W'(lvl);
  assign too_few  = (WIDE_W'(cmd.count) > lvl_wide);
  assign take_lim = too_few ? lvl_wide[CNT_W-1:0] : cmd.count;
  assign is_eol   = (rd_data == CH_LF) || (rd_data == CH_CR);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign wr_en    = q_pop && (cmd.kind == CMD_PUSH) && !full;

  // Only used when the drop succeeds, so the sum stays below twice DEPTH.
  always_comb begin
    drop_sum = WIDE_W'(head) + WIDE_W'(cmd.count);
    if (drop_sum >= WIDE_W'(DEPTH)) drop_sum = drop_sum - WIDE_W'(DEPTH);
    drop_head = drop_sum[PTR_W-1:0];
  end

  assign rd_addr = (state == S_SCAN_RD) ? scan_addr : head_inc;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      storage[tail_inc] <= cmd.data;
    end
    rd_data <= storage[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      tail   <= '0;
      strobe <= 1'b0;
    end else begin
      strobe   <= 1'b0;
      out_byte <= '0;
      has_byte <= 1'b0;
      status   <= 1'b0;
      last     <= 1'b1;
      level    <= lvl6(lvl);
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            unique case (cmd.kind)
              CMD_PUSH: begin
                strobe <= 1'b1;
                if (full) begin
                  status <= 1'b1;
                end else begin
                  tail  <= tail_inc;
                  level <= lvl6(lvl_push);
                end
              end
              CMD_POP: begin
                if (take_lim == '0) begin
                  strobe <= 1'b1;
                  status <= (cmd.count != '0);
                end else begin
                  rem   <= take_lim;
                  state <= S_POP_RD;
                end
              end
              CMD_DROP: begin
                strobe <= 1'b1;
                if (too_few) begin
                  status <= 1'b1;
                end else begin
                  head  <= drop_head;
                  level <= lvl6(fill(tail, drop_head));
                end
              end
              CMD_TAKE: begin
                if (take_lim == '0) begin
                  strobe <= 1'b1;
                  status <= 1'b1;
                end else begin
                  lim       <= take_lim;
                  idx       <= '0;
                  scan_addr <= head_inc;
                  state     <= S_SCAN_RD;
                end
              end
              CMD_SKIP: begin
                if (lvl == '0) begin
                  strobe <= 1'b1;
                end else begin
                  state <= S_SKIP_RD;
                end
              end
              default: begin
                strobe <= 1'b1;
                status <= 1'b1;
              end
            endcase
          end
        end
        S_POP_RD: begin
          state <= S_POP_OUT;
        end
        S_POP_OUT: begin
          strobe   <= 1'b1;
          out_byte <= rd_data;
          has_byte <= 1'b1;
          last     <= (rem == CNT_W'(1));
          level    <= lvl6(lvl_adv);
          head     <= head_inc;
          rem      <= rem - 1'b1;
          state    <= (rem == CNT_W'(1)) ? S_IDLE : S_POP_RD;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (rd_data == CH_LF) begin
            rem   <= idx + 1'b1;
            state <= S_POP_RD;
          end else if (CNT_W'(idx + 1'b1) == lim) begin
            strobe <= 1'b1;
            status <= 1'b1;
            state  <= S_IDLE;
          end else begin
            idx       <= idx + 1'b1;
            scan_addr <= ptr_inc(scan_addr);
            state     <= S_SCAN_RD;
          end
        end
        S_SKIP_RD: begin
          state <= S_SKIP_CHK;
        end
        S_SKIP_CHK: begin
          if (is_eol) begin
            head <= head_inc;
            if (lvl_adv == '0) begin
              strobe <= 1'b1;
              level  <= '0;
              state  <= S_IDLE;
            end else begin
              state <= S_SKIP_RD;
            end
          end else begin
            strobe <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
